/* src/sfls_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the streaming substring search block.
// No dependencies; imported by every module under src.
package sfls_pkg;

    localparam int NEEDLE_MAX     = 8;
    localparam int INDEX_BITS     = 16;
    localparam int LEN_BITS       = $clog2(NEEDLE_MAX + 1);
    localparam int NEEDLE_BITS    = 64;
    localparam int NLEN_BITS      = 4;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 2;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_NEEDLE_BYTES  = 2'd0,
        REG_NEEDLE_LENGTH = 2'd1,
        REG_SEARCH_FROM   = 2'd2,
        REG_SEARCH_LAST   = 2'd3
    } cfg_reg_t;

    // What the back end has to do with a queued request
    typedef enum logic [1:0] {
        OP_BYTE     = 2'd0,
        OP_BYTE_END = 2'd1,
        OP_END      = 2'd2
    } op_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_string;
        logic       no_char;
    } in_item_t;

    typedef struct packed {
        logic                  found;
        logic [INDEX_BITS-1:0] match_index;
        logic                  too_long;
    } out_item_t;

    typedef struct packed {
        logic [NEEDLE_BITS-1:0] needle_bytes;
        logic [NLEN_BITS-1:0]   needle_length;
        logic [INDEX_BITS-1:0]  search_from;
        logic                   search_last;
    } cfg_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] char_byte;
    } queue_entry_t;

    typedef logic [NEEDLE_MAX-1:0][7:0] window_t;

endpackage

/* src/sfls_front.sv */
`timescale 1ns / 1ps
// Front end: takes input requests, classifies them and drops the empty ones.
// Depends on sfls_pkg.
module sfls_front
    import sfls_pkg::*;
(
    input  logic         s_valid,
    output logic         s_ready,
    input  in_item_t     s_item,
    input  logic         q_full,
    output logic         q_push,
    output queue_entry_t q_entry
);

    logic keep;

    // no byte and no end mark: nothing to do
    assign keep    = s_item.end_of_string | ~s_item.no_char;
    assign s_ready = ~q_full;
    assign q_push  = s_valid & s_ready & keep;

    always_comb begin
        q_entry.char_byte = s_item.char_byte;
        if (s_item.no_char) begin
            q_entry.op = OP_END;
        end else if (s_item.end_of_string) begin
            q_entry.op = OP_BYTE_END;
        end else begin
            q_entry.op = OP_BYTE;
        end
    end

endmodule

/* src/sfls_queue.sv */
`timescale 1ns / 1ps
// Small request queue between the front and back ends.
// Depends on sfls_pkg.
module sfls_queue
    import sfls_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  queue_entry_t push_entry,
    input  logic         pop,
    output logic         full,
    output logic         head_valid,
    output queue_entry_t head
);

    queue_entry_t mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;
    logic                 do_pop;

    assign full       = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop & head_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* src/sfls_back.sv */
`timescale 1ns / 1ps
// Back end: byte window, needle compare, hit tracking and the result register.
// Depends on sfls_pkg.
module sfls_back
    import sfls_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  cfg_t         cfg,
    input  logic         q_valid,
    input  queue_entry_t q_head,
    output logic         q_pop,
    output logic         m_valid,
    input  logic         m_ready,
    output out_item_t    m_item
);

    localparam logic [INDEX_BITS-1:0] POS_MAX = '1;

    window_t               window_reg, window_next, win_b;
    logic [INDEX_BITS-1:0] position_reg, position_next, pos_b;
    logic                  hit_seen_reg, hit_seen_next, hit_seen_b;
    logic [INDEX_BITS-1:0] hit_index_reg, hit_index_next, hit_index_b;
    logic                  overflowed_reg, overflowed_next, ovf_b;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_item_reg, m_item_next;

    logic                     has_byte, has_end;
    logic [LEN_BITS-1:0]      len;
    logic [INDEX_BITS-1:0]    len_ext, start, from;
    logic                     match, take;
    logic [(1<<LEN_BITS)-1:0] hits;

    // one compare result per needle length; entry 0 is never used
    function automatic logic [(1<<LEN_BITS)-1:0] window_hits(
        input window_t w, input logic [NEEDLE_BITS-1:0] nb);
        logic [(1<<LEN_BITS)-1:0] hits;
        logic [7:0]               nbyte;
        hits = '0;
        for (int l = 1; l <= NEEDLE_MAX; l++) begin
            hits[l] = 1'b1;
            for (int k = 0; k < l; k++) begin
                // window[0] is newest, so the needle starts at window[l-1]
                if ((l - 1 - k) < NEEDLE_BITS / 8) begin
                    nbyte = nb[8*(l-1-k) +: 8];
                end else begin
                    nbyte = 8'd0;
                end
                if (w[k] != nbyte) begin
                    hits[l] = 1'b0;
                end
            end
        end
        return hits;
    endfunction

    assign has_byte = (q_head.op == OP_BYTE) || (q_head.op == OP_BYTE_END);
    assign has_end  = (q_head.op == OP_BYTE_END) || (q_head.op == OP_END);
    assign q_pop    = q_valid & (~has_end | ~m_valid_reg | m_ready);

    assign len     = (cfg.needle_length > NLEN_BITS'(NEEDLE_MAX)) ?
                     LEN_BITS'(NEEDLE_MAX) : LEN_BITS'(cfg.needle_length);
    assign len_ext = INDEX_BITS'(len);
    assign from    = cfg.search_from;

    always_comb begin
        // state as it stands once this byte is taken
        ovf_b = overflowed_reg | (position_reg == POS_MAX);
        pos_b = (position_reg == POS_MAX) ? position_reg : position_reg + 1'b1;
        win_b = window_reg;
        for (int i = NEEDLE_MAX - 1; i > 0; i--) begin
            win_b[i] = window_reg[i-1];
        end
        win_b[0] = q_head.char_byte;

        hits  = window_hits(win_b, cfg.needle_bytes);
        match = (len != '0) && !ovf_b && (pos_b >= len_ext) && hits[len];
        start = pos_b - len_ext;
        if (cfg.search_last) begin
            take = match && (start <= from);
        end else begin
            take = match && !hit_seen_reg && (start >= from);
        end
        hit_seen_b  = hit_seen_reg | take;
        hit_index_b = take ? start : hit_index_reg;

        window_next     = window_reg;
        position_next   = position_reg;
        hit_seen_next   = hit_seen_reg;
        hit_index_next  = hit_index_reg;
        overflowed_next = overflowed_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_item_next     = m_item_reg;

        if (q_pop) begin
            if (has_byte) begin
                window_next     = win_b;
                position_next   = pos_b;
                hit_seen_next   = hit_seen_b;
                hit_index_next  = hit_index_b;
                overflowed_next = ovf_b;
            end
            if (has_end) begin
                m_valid_next         = 1'b1;
                m_item_next.too_long = overflowed_next;
                if (len == '0) begin
                    m_item_next.found = 1'b1;
                    if (cfg.search_last || (position_next <= from)) begin
                        m_item_next.match_index = position_next;
                    end else begin
                        m_item_next.match_index = from;
                    end
                end else begin
                    m_item_next.found       = hit_seen_next;
                    m_item_next.match_index = hit_seen_next ? hit_index_next : '0;
                end
                // stream state back to its start; the window is masked by position
                position_next   = '0;
                hit_seen_next   = 1'b0;
                hit_index_next  = '0;
                overflowed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        window_reg <= window_next;
        m_item_reg <= m_item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg   <= '0;
            hit_seen_reg   <= 1'b0;
            hit_index_reg  <= '0;
            overflowed_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            position_reg   <= position_next;
            hit_seen_reg   <= hit_seen_next;
            hit_index_reg  <= hit_index_next;
            overflowed_reg <= overflowed_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

/* src/substring_first_last_search.sv */
`timescale 1ns / 1ps
// Streaming substring search, first or last occurrence of a needle of up to eight bytes.
// Throughput: one byte request a cycle until the queue fills; the back end pops one a cycle.
// A result is registered when the back end pops the queued request that ends the string.
// A stalled result holds the next end mark; the four-entry queue fills before s_ready drops.
// Reset is synchronous, active low, and clears the registers, the queue and the stream state.
module substring_first_last_search
    import sfls_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  in_item_t                  s_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output out_item_t                 m_item
);

    cfg_t         cfg_reg, cfg_next;
    logic         q_full, q_push, q_pop, q_valid;
    queue_entry_t q_entry, q_head;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_NEEDLE_BYTES:  cfg_next.needle_bytes  = cfg_wdata[NEEDLE_BITS-1:0];
                REG_NEEDLE_LENGTH: cfg_next.needle_length = cfg_wdata[NLEN_BITS-1:0];
                REG_SEARCH_FROM:   cfg_next.search_from   = cfg_wdata[INDEX_BITS-1:0];
                REG_SEARCH_LAST:   cfg_next.search_last   = cfg_wdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sfls_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    sfls_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_head)
    );

    sfls_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

/* tb/sv/sfls_search_checker.sv */
`timescale 1ns / 1ps
// Checker for the substring search block: follows register writes and byte requests,
// predicts each search result and compares it with what the block returns.
// Depends on sfls_pkg for the channel, register and index types.
module sfls_search_checker
    import sfls_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  in_item_t                  s_item,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  out_item_t                 m_item,
    output int                        fail_count,
    output int                        pending
);

    // register copies
    logic [NEEDLE_BITS-1:0] ndl_bytes;
    logic [NLEN_BITS-1:0]   ndl_len;
    logic [INDEX_BITS-1:0]  from_idx;
    logic                   last_mode;

    // per-string search state
    logic [7:0]            hist [NEEDLE_MAX];
    logic [INDEX_BITS-1:0] seen_len;
    logic                  hit_seen;
    logic [INDEX_BITS-1:0] hit_at;
    logic                  ovf;

    out_item_t result_q[$];

    function automatic int eff_len();
        int n = int'(ndl_len);
        return (n > NEEDLE_MAX) ? NEEDLE_MAX : n;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] search result mismatch, %s: got %0h, expected %0h",
                 $time, what, got, want);
        fail_count++;
    endtask

    task automatic clear_search();
        for (int i = 0; i < NEEDLE_MAX; i++) hist[i] = '0;
        seen_len = '0;
        hit_seen = 1'b0;
        hit_at   = '0;
        ovf      = 1'b0;
    endtask

    task automatic take_char(input logic [7:0] c);
        int                    n;
        logic                  same;
        logic [INDEX_BITS-1:0] start;
        n = eff_len();
        if (seen_len == '1) ovf = 1'b1;
        else seen_len++;
        for (int i = NEEDLE_MAX - 1; i > 0; i--) hist[i] = hist[i-1];
        hist[0] = c;
        // nothing is recorded once the length counter has saturated
        if (ovf || n == 0 || seen_len < n) return;
        same = 1'b1;
        for (int j = 0; j < n; j++)
            if (hist[n-1-j] != ndl_bytes[8*j +: 8]) same = 1'b0;
        if (!same) return;
        start = seen_len - INDEX_BITS'(n);
        if (last_mode) begin
            if (start <= from_idx) begin
                hit_seen = 1'b1;
                hit_at   = start;
            end
        end else if (!hit_seen && start >= from_idx) begin
            hit_seen = 1'b1;
            hit_at   = start;
        end
    endtask

    task automatic close_string();
        out_item_t r;
        r = '0;
        if (eff_len() == 0) begin
            r.found = 1'b1;
            if (last_mode) r.match_index = seen_len;
            else r.match_index = (from_idx < seen_len) ? from_idx : seen_len;
        end else if (hit_seen) begin
            r.found       = 1'b1;
            r.match_index = hit_at;
        end
        r.too_long = ovf;
        result_q.push_back(r);
        clear_search();
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            ndl_bytes  = '0;
            ndl_len    = '0;
            from_idx   = '0;
            last_mode  = 1'b0;
            fail_count = 0;
            clear_search();
            result_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    REG_NEEDLE_BYTES:  ndl_bytes = cfg_wdata[NEEDLE_BITS-1:0];
                    REG_NEEDLE_LENGTH: ndl_len   = cfg_wdata[NLEN_BITS-1:0];
                    REG_SEARCH_FROM:   from_idx  = cfg_wdata[INDEX_BITS-1:0];
                    REG_SEARCH_LAST:   last_mode = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("result with none outstanding", 32'(m_item), 32'd0);
                end else begin
                    want = result_q.pop_front();
                    if (m_item.found !== want.found)
                        report_mismatch("found", 32'(m_item.found), 32'(want.found));
                    if (m_item.match_index !== want.match_index)
                        report_mismatch("match_index", 32'(m_item.match_index),
                                        32'(want.match_index));
                    if (m_item.too_long !== want.too_long)
                        report_mismatch("too_long", 32'(m_item.too_long), 32'(want.too_long));
                end
            end
            if (s_valid && s_ready) begin
                if (!s_item.no_char) take_char(s_item.char_byte);
                if (s_item.end_of_string) close_string();
            end
        end
        pending = result_q.size();
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Top of the substring search testbench: clock, reset, register writes and byte requests.
// Depends on sfls_pkg, substring_first_last_search and sfls_search_checker.
module tb;
    import sfls_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int SETTLE       = 12;
    localparam int RANDOM_ITEMS = 1950;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_NEEDLE_BYTES;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    in_item_t                  s_item    = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    out_item_t                 m_item;

    int fail_count;
    int pending;
    int cycles = 0;
    int sent   = 0;
    bit calm   = 1'b0;

    logic [7:0] alpha [3];
    int         alpha_n;

    substring_first_last_search dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    sfls_search_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** substring_first_last_search: FAILED **");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready = calm || ($urandom_range(99) >= 29);
    end

    // Called at a falling edge; returns at the falling edge after acceptance with valid
    // still high, so a following request goes straight out.
    task automatic send_item(input in_item_t it);
        while (!calm && $urandom_range(99) < 29) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_item  = it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (!it.no_char || it.end_of_string) sent++;
    endtask

    task automatic send_char(input logic [7:0] c, input bit last);
        in_item_t it;
        it.char_byte     = c;
        it.end_of_string = last;
        it.no_char       = 1'b0;
        send_item(it);
    endtask

    // request with no byte: closes the string or, without the end mark, is ignored
    task automatic send_blank(input bit last);
        in_item_t it;
        it.char_byte     = 8'($urandom);
        it.end_of_string = last;
        it.no_char       = 1'b1;
        send_item(it);
    endtask

    task automatic send_text(input string txt);
        if (txt.len() == 0) send_blank(1'b1);
        for (int i = 0; i < txt.len(); i++) send_char(txt[i], i == txt.len() - 1);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_search(input logic [63:0] nb, input int nl, input int sf, input bit sl);
        drain();
        write_reg(REG_NEEDLE_BYTES, nb);
        write_reg(REG_NEEDLE_LENGTH, 64'(nl));
        write_reg(REG_SEARCH_FROM, 64'(sf));
        write_reg(REG_SEARCH_LAST, 64'(sl));
    endtask

    task automatic pick_search();
        logic [63:0] nb;
        int          nl;
        int          sf;
        alpha_n = $urandom_range(1, 3);
        for (int i = 0; i < 3; i++) alpha[i] = 8'($urandom);
        for (int i = 0; i < 8; i++) nb[8*i +: 8] = alpha[$urandom_range(0, alpha_n - 1)];
        case ($urandom_range(0, 9))
            0:       nl = 0;
            1:       nl = $urandom_range(9, 15);
            default: nl = $urandom_range(1, 8);
        endcase
        // bytes past the needle length should not matter
        if ($urandom_range(3) == 0)
            for (int i = nl; i < 8; i++) nb[8*i +: 8] = 8'($urandom);
        case ($urandom_range(0, 5))
            0:       sf = 0;
            1:       sf = 65535;
            4:       sf = $urandom_range(0, 65535);
            default: sf = $urandom_range(0, 24);
        endcase
        set_search(nb, nl, sf, $urandom_range(1));
    endtask

    task automatic send_random_string();
        int         len;
        bit         blank_end;
        logic [7:0] c;
        len       = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 20);
        blank_end = (len == 0) || ($urandom_range(3) == 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(19) == 0) send_blank(1'b0);
            c = ($urandom_range(99) < 85) ? alpha[$urandom_range(0, alpha_n - 1)]
                                          : 8'($urandom);
            send_char(c, !blank_end && i == len - 1);
        end
        if (blank_end) send_blank(1'b1);
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // registers at reset: empty needle, first mode from zero
        send_text("");
        set_search(64'h6261, 2, 0, 1'b0);
        send_text("xabab");
        send_blank(1'b0);
        send_text("zab");
        send_text("");
        send_char("a", 1'b0);
        send_char("b", 1'b0);
        send_blank(1'b1);
        set_search(64'h6261, 2, 65535, 1'b1);
        send_text("abab");
        set_search(64'h6261, 2, 1, 1'b1);
        send_text("abab");
        send_text("ba");
        // length above eight saturates
        set_search('1, 9, 65535, 1'b1);
        for (int i = 0; i < 9; i++) send_char(8'hff, i == 8);
        set_search('0, 15, 0, 1'b0);
        for (int i = 0; i < 9; i++) send_char(8'h00, i == 8);
        set_search(64'h0, 0, 3, 1'b0);
        send_text("hello");
        set_search(64'h0, 0, 3, 1'b1);
        send_text("hello");
        set_search(64'h64636261, 4, 0, 1'b0);
        send_text("ab");

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            calm = (sent >= 700 && sent < 1000);
            pick_search();
            repeat ($urandom_range(3, 8)) send_random_string();
        end
        calm = 1'b0;

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("** substring_first_last_search: PASSED **");
        end else begin
            $display("** substring_first_last_search: FAILED **");
        end
        $finish;
    end

endmodule
